@@ hdl/hsvskin_pkg.sv @@
// Shared types, widths and constants of the HSV skin pixel classifier.
package hsvskin_pkg;

   localparam int unsigned CHAN_W = 8;
   localparam int unsigned HUE_W  = 9;
   localparam int unsigned SAT_W  = 7;
   localparam int unsigned CSR_W  = 9;
   localparam int unsigned HN_W   = 17;
   localparam int unsigned SATP_W = 15;

   localparam logic [HUE_W-1:0] HUE_LOW_RESET  = 9'd13;
   localparam logic [HUE_W-1:0] HUE_HIGH_RESET = 9'd42;
   localparam logic [SAT_W-1:0] SAT_LOW_RESET  = 7'd15;
   localparam logic [SAT_W-1:0] SAT_HIGH_RESET = 7'd40;

   // Saturation bounds are in hundredths, so the spread is scaled by this.
   localparam logic [SATP_W-1:0] SAT_SCALE = 15'd100;

   typedef enum logic [1:0] {
      CSR_HUE_LOW  = 2'd0,
      CSR_HUE_HIGH = 2'd1,
      CSR_SAT_LOW  = 2'd2,
      CSR_SAT_HIGH = 2'd3
   } csr_index_type;

   // Per-pixel values handed from the hue stage to the bound tests.
   typedef struct packed {
      logic              nonzero;
      logic [CHAN_W-1:0] mx;
      logic [CHAN_W-1:0] d;
      logic [HN_W-1:0]   hn;
   } pix_prep_type;

endpackage

@@ hdl/hsvskin_prep.sv @@
// Maximum, minimum, spread and hue numerator of one RGB pixel.
module hsvskin_prep import hsvskin_pkg::*; (
   input  logic [CHAN_W-1:0] red,
   input  logic [CHAN_W-1:0] green,
   input  logic [CHAN_W-1:0] blue,
   output pix_prep_type      prep
);

   logic              blue_max;
   logic              green_max;
   logic [CHAN_W-1:0] mx;
   logic [CHAN_W-1:0] mn;
   logic [CHAN_W-1:0] d;
   logic [18:0]       d19;
   logic signed [8:0] diff_s;
   logic signed [18:0] term_s;
   logic signed [18:0] hn_s;

   always_comb begin
      blue_max  = (blue >= red) && (blue >= green);
      green_max = (green >= red);

      mx = red;
      if (green > mx) begin
         mx = green;
      end
      if (blue > mx) begin
         mx = blue;
      end
      mn = red;
      if (green < mn) begin
         mn = green;
      end
      if (blue < mn) begin
         mn = blue;
      end
      d   = mx - mn;
      d19 = 19'(d);

      // The hue is kept as a numerator over the spread: H = hn / d.
      if (blue_max) begin
         diff_s = $signed({1'b0, red}) - $signed({1'b0, green});
      end else if (green_max) begin
         diff_s = $signed({1'b0, blue}) - $signed({1'b0, red});
      end else begin
         diff_s = $signed({1'b0, green}) - $signed({1'b0, blue});
      end
      term_s = 19'(diff_s) * 19'sd60;

      if (blue_max) begin
         hn_s = $signed(d19 * 19'd240) + term_s;
      end else if (green_max) begin
         hn_s = $signed(d19 * 19'd120) + term_s;
      end else if (term_s < 19'sd0) begin
         hn_s = $signed(d19 * 19'd360) + term_s;
      end else begin
         hn_s = term_s;
      end

      prep.nonzero = (d != '0);
      prep.mx      = mx;
      prep.d       = d;
      prep.hn      = hn_s[HN_W-1:0];
   end

endmodule

@@ hdl/hsv_skin_pixel_classifier.sv @@
// A pixel taken by the input register moves on through the hue and result registers.
// One pixel per clock unless stalled; input, hue and result registers form a three-stage pipe.
// Back-pressure from rsp_ready holds only full stages: a stage keeps its beat while the one
// after it is full and held, and an empty stage still takes a beat, so bubbles close up.
// Reset (synchronous, active high) empties the pipe and restores the default bounds:
// hue 13..42 degrees and saturation 15..40 hundredths, all exclusive.
module hsv_skin_pixel_classifier import hsvskin_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CHAN_W-1:0] req_red,
   input  logic [CHAN_W-1:0] req_green,
   input  logic [CHAN_W-1:0] req_blue,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_is_skin,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [CSR_W-1:0]  csr_wdata
);

   // Bound registers.
   logic [HUE_W-1:0] hue_low_ff,  hue_low_in;
   logic [HUE_W-1:0] hue_high_ff, hue_high_in;
   logic [SAT_W-1:0] sat_low_ff,  sat_low_in;
   logic [SAT_W-1:0] sat_high_ff, sat_high_in;

   // Stage one holds the raw pixel, stage two the hue numerator and spread,
   // stage three the classified beat that waits on the output.
   logic              s1_valid_ff, s1_valid_in;
   logic [CHAN_W-1:0] s1_red_ff, s1_green_ff, s1_blue_ff;
   logic              s2_valid_ff, s2_valid_in;
   pix_prep_type      s2_prep_ff, s2_prep_in;
   logic              s3_valid_ff, s3_valid_in;
   logic              s3_skin_ff, s3_skin_in;

   logic out_free;
   logic s2_free;
   logic s1_free;
   logic s2_adv;
   logic s1_adv;
   logic req_take;

   logic [HN_W-1:0]   hue_lo_prod;
   logic [HN_W-1:0]   hue_hi_prod;
   logic [SATP_W-1:0] sat_lo_prod;
   logic [SATP_W-1:0] sat_hi_prod;
   logic [SATP_W-1:0] d_scaled;

   // A stage can take a new beat when it is empty or its beat moves on in
   // the same cycle; the chain runs back from the output handshake.
   assign out_free  = !s3_valid_ff || rsp_ready;
   assign s2_adv    = s2_valid_ff && out_free;
   assign s2_free   = !s2_valid_ff || out_free;
   assign s1_adv    = s1_valid_ff && s2_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_ready = s1_free;
   assign req_take  = req_valid && req_ready;

   assign rsp_valid   = s3_valid_ff;
   assign rsp_is_skin = s3_skin_ff;

   hsvskin_prep u_prep (
      .red   (s1_red_ff),
      .green (s1_green_ff),
      .blue  (s1_blue_ff),
      .prep  (s2_prep_in)
   );

   // Exact bound tests by cross-multiplication: hue_low < hn/d < hue_high and
   // sat_low/100 < d/mx < sat_high/100. A zero spread (black or gray) never passes.
   always_comb begin
      hue_lo_prod = HN_W'(hue_low_ff)  * HN_W'(s2_prep_ff.d);
      hue_hi_prod = HN_W'(hue_high_ff) * HN_W'(s2_prep_ff.d);
      sat_lo_prod = SATP_W'(sat_low_ff)  * SATP_W'(s2_prep_ff.mx);
      sat_hi_prod = SATP_W'(sat_high_ff) * SATP_W'(s2_prep_ff.mx);
      d_scaled    = SATP_W'(s2_prep_ff.d) * SAT_SCALE;
      s3_skin_in  = s2_prep_ff.nonzero
                    && (hue_lo_prod < s2_prep_ff.hn)
                    && (s2_prep_ff.hn < hue_hi_prod)
                    && (sat_lo_prod < d_scaled)
                    && (d_scaled < sat_hi_prod);
   end

   // Register writes; an index outside the list is ignored.
   always_comb begin
      hue_low_in  = hue_low_ff;
      hue_high_in = hue_high_ff;
      sat_low_in  = sat_low_ff;
      sat_high_in = sat_high_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_HUE_LOW:  hue_low_in  = csr_wdata[HUE_W-1:0];
            CSR_HUE_HIGH: hue_high_in = csr_wdata[HUE_W-1:0];
            CSR_SAT_LOW:  sat_low_in  = csr_wdata[SAT_W-1:0];
            CSR_SAT_HIGH: sat_high_in = csr_wdata[SAT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      s1_valid_in = req_take || (s1_valid_ff && !s2_free);
      s2_valid_in = s1_adv   || (s2_valid_ff && !out_free);
      s3_valid_in = s2_adv   || (s3_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_low_ff  <= HUE_LOW_RESET;
         hue_high_ff <= HUE_HIGH_RESET;
         sat_low_ff  <= SAT_LOW_RESET;
         sat_high_ff <= SAT_HIGH_RESET;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         hue_low_ff  <= hue_low_in;
         hue_high_ff <= hue_high_in;
         sat_low_ff  <= sat_low_in;
         sat_high_ff <= sat_high_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // Payload registers load only when their stage takes a beat.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_red_ff   <= req_red;
         s1_green_ff <= req_green;
         s1_blue_ff  <= req_blue;
      end
      if (s1_adv) begin
         s2_prep_ff <= s2_prep_in;
      end
      if (s2_adv) begin
         s3_skin_ff <= s3_skin_in;
      end
   end

`ifndef SYNTHESIS
   // A stalled middle stage keeps its beat.
   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !out_free) |=> (s2_valid_ff && $stable(s2_prep_ff)))
      else $error("hue stage lost or changed a stalled beat");

   // A gray or black pixel never leaves as skin.
   a_gray_not_skin: assert property (@(posedge clock) disable iff (reset)
      (s2_adv && !s2_prep_ff.nonzero) |=> !rsp_is_skin)
      else $error("zero-spread pixel classified as skin");

   // Hue bounds that leave no room reject every pixel.
   a_empty_hue_band: assert property (@(posedge clock) disable iff (reset)
      (s2_adv && (hue_low_ff >= hue_high_ff)) |=> !rsp_is_skin)
      else $error("pixel passed an empty hue band");
`endif

endmodule

@@ tb/hsv_skin_checker.sv @@
// Scoreboard for the HSV skin pixel classifier: predicts each result beat and compares it.
`timescale 1ns / 1ps

module hsv_skin_checker import hsvskin_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [CHAN_W-1:0] req_red,
   input  logic [CHAN_W-1:0] req_green,
   input  logic [CHAN_W-1:0] req_blue,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic              rsp_is_skin,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [CSR_W-1:0]  csr_wdata,
   output int                fail_count,
   output int                pending_count
);

   localparam int PCT_SCALE   = 100;
   localparam int PRINT_LIMIT = 40;

   // Shadow copy of the bound registers.
   logic [HUE_W-1:0] hue_low_bound;
   logic [HUE_W-1:0] hue_high_bound;
   logic [SAT_W-1:0] sat_low_bound;
   logic [SAT_W-1:0] sat_high_bound;

   logic skin_expected_q[$];
   logic want_skin;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   // Exact skin test: hue is kept as a numerator over the spread, and every bound
   // check is a cross-multiplication, so no division or rounding is involved.
   function automatic logic skin_verdict(input logic [CHAN_W-1:0] r, g, b);
      int rv, gv, bv, mx, mn, d, hn;
      rv = int'(r);
      gv = int'(g);
      bv = int'(b);
      mx = rv;
      if (gv > mx) mx = gv;
      if (bv > mx) mx = bv;
      mn = rv;
      if (gv < mn) mn = gv;
      if (bv < mn) mn = bv;
      d = mx - mn;
      if (d == 0) return 1'b0;
      // Blue maximum wins over green, green over red.
      if (mx == bv) begin
         hn = 240 * d + 60 * (rv - gv);
      end else if (mx == gv) begin
         hn = 120 * d + 60 * (bv - rv);
      end else begin
         hn = 60 * (gv - bv);
         if (hn < 0) hn += 360 * d;
      end
      return (int'(hue_low_bound) * d < hn) && (hn < int'(hue_high_bound) * d) &&
             (int'(sat_low_bound) * mx < PCT_SCALE * d) &&
             (PCT_SCALE * d < int'(sat_high_bound) * mx);
   endfunction

   task automatic report_mismatch(input string what);
      if (fail_count < PRINT_LIMIT) $display("MISMATCH at %0t ns: %s", $time, what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         skin_expected_q.delete();
         hue_low_bound  = HUE_LOW_RESET;
         hue_high_bound = HUE_HIGH_RESET;
         sat_low_bound  = SAT_LOW_RESET;
         sat_high_bound = SAT_HIGH_RESET;
         pending_count <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_HUE_LOW:  hue_low_bound  = csr_wdata[HUE_W-1:0];
               CSR_HUE_HIGH: hue_high_bound = csr_wdata[HUE_W-1:0];
               CSR_SAT_LOW:  sat_low_bound  = csr_wdata[SAT_W-1:0];
               CSR_SAT_HIGH: sat_high_bound = csr_wdata[SAT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            skin_expected_q.push_back(skin_verdict(req_red, req_green, req_blue));
         if (rsp_valid && rsp_ready) begin
            if (skin_expected_q.size() == 0) begin
               report_mismatch("result beat with no pixel outstanding");
            end else begin
               want_skin = skin_expected_q.pop_front();
               if (rsp_is_skin !== want_skin)
                  report_mismatch($sformatf("is_skin is %b, predicted %b",
                                            rsp_is_skin, want_skin));
            end
         end
         pending_count <= skin_expected_q.size();
      end
   end

endmodule

@@ tb/testbench.sv @@
// Top of the classifier testbench: clock, reset, pixel and bound stimulus, and the verdict.
`timescale 1ns / 1ps

module testbench;
   import hsvskin_pkg::*;

   // Every pixel makes exactly one result, so the run is short; the limit leaves
   // a wide margin for random stalls on both channels.
   localparam int CYCLE_LIMIT    = 200000;
   localparam int PHASE_COUNT    = 9;
   localparam int PHASE_PIXELS   = 134;
   localparam int STALL_PCT      = 29;
   localparam int PIPE_SETTLE    = 6;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [CHAN_W-1:0] req_red = '0;
   logic [CHAN_W-1:0] req_green = '0;
   logic [CHAN_W-1:0] req_blue = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_is_skin;
   logic              csr_wr_en = 1'b0;
   logic [1:0]        csr_index = CSR_HUE_LOW;
   logic [CSR_W-1:0]  csr_wdata = '0;

   int fail_count;
   int pending_count;
   int cycle_count = 0;
   // Percentage of cycles in which each side holds back; zero during the calm phases.
   int stall_pct = STALL_PCT;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   hsv_skin_pixel_classifier dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_red    (req_red),
      .req_green  (req_green),
      .req_blue   (req_blue),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_is_skin(rsp_is_skin),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   hsv_skin_checker scoreboard (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_red      (req_red),
      .req_green    (req_green),
      .req_blue     (req_blue),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_is_skin  (rsp_is_skin),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .fail_count   (fail_count),
      .pending_count(pending_count)
   );

   // The result side drops ready at random, which stalls the whole pipe and lets
   // back-pressure land on every stage.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog: a hung handshake or a lost result beat ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Offers one pixel and returns at the edge where it is taken. Valid is only
   // lowered during a random gap, so back-to-back beats keep it high without a
   // second assignment in the same time step.
   task automatic send_pixel(input logic [CHAN_W-1:0] r, g, b);
      while ($urandom_range(99) < stall_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Waits until every outstanding pixel has produced its result, then lets the
   // pipe settle so that a stray extra beat would still be caught.
   task automatic drain_pipe();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (PIPE_SETTLE) @(posedge clock);
   endtask

   // Writes all four bounds one after another, hue low first and saturation high
   // last; the enable is raised once and lowered once, after the last write.
   task automatic set_bounds(input int hue_lo, hue_hi, sat_lo, sat_hi);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_HUE_LOW;
      csr_wdata <= CSR_W'(hue_lo);
      @(posedge clock);
      csr_index <= CSR_HUE_HIGH;
      csr_wdata <= CSR_W'(hue_hi);
      @(posedge clock);
      csr_index <= CSR_SAT_LOW;
      csr_wdata <= CSR_W'(sat_lo);
      @(posedge clock);
      csr_index <= CSR_SAT_HIGH;
      csr_wdata <= CSR_W'(sat_hi);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Picks a pixel from one of several families. Four in ten lie near the default skin
   // band (red maximum, modest spread); the rest cover gray levels, ties between the
   // maximum channels, saturated extremes, green or blue leads and plain random colors.
   task automatic pick_pixel(output logic [CHAN_W-1:0] r, g, b);
      int family;
      int hi, lo, mid;
      family = $urandom_range(9);
      case (family)
         0, 1, 2, 3: begin
            hi = $urandom_range(255, 40);
            lo = $urandom_range(hi, hi / 2);
            mid = $urandom_range(hi, lo);
            r = CHAN_W'(hi);
            g = CHAN_W'(mid);
            b = CHAN_W'(lo);
         end
         4, 5: begin
            r = CHAN_W'($urandom);
            g = CHAN_W'($urandom);
            b = CHAN_W'($urandom);
         end
         6: begin
            r = CHAN_W'($urandom);
            g = r;
            b = r;
         end
         7: begin
            // Two channels share the maximum, which exercises the precedence rule.
            hi = $urandom_range(255);
            lo = $urandom_range(hi);
            case ($urandom_range(2))
               0: begin r = CHAN_W'(hi); g = CHAN_W'(hi); b = CHAN_W'(lo); end
               1: begin r = CHAN_W'(lo); g = CHAN_W'(hi); b = CHAN_W'(hi); end
               default: begin r = CHAN_W'(hi); g = CHAN_W'(lo); b = CHAN_W'(hi); end
            endcase
         end
         8: begin
            r = ($urandom_range(2) == 0) ? 8'd0 : (($urandom_range(1) == 0) ? 8'd255
                                                                        : CHAN_W'($urandom));
            g = ($urandom_range(2) == 0) ? 8'd0 : (($urandom_range(1) == 0) ? 8'd255
                                                                        : CHAN_W'($urandom));
            b = ($urandom_range(2) == 0) ? 8'd0 : (($urandom_range(1) == 0) ? 8'd255
                                                                        : CHAN_W'($urandom));
         end
         default: begin
            // Green or blue leads, reaching the upper parts of the hue circle.
            hi = $urandom_range(255, 1);
            lo = $urandom_range(hi);
            mid = $urandom_range(hi);
            r = CHAN_W'(lo);
            if ($urandom_range(1) == 0) begin
               g = CHAN_W'(hi);
               b = CHAN_W'(mid);
            end else begin
               g = CHAN_W'(mid);
               b = CHAN_W'(hi);
            end
         end
      endcase
   endtask

   initial begin
      // Bound settings per random phase: low hue, high hue, low and high saturation.
      // They include the full legal range, bounds that admit nothing, values past
      // the stated range up to the field maximum, and a last fully random one.
      static int phase_hue_lo[PHASE_COUNT] = '{13, 0,   0,   511, 0,   200, 300, 60,  0};
      static int phase_hue_hi[PHASE_COUNT] = '{42, 360, 0,   511, 511, 100, 360, 180, 0};
      static int phase_sat_lo[PHASE_COUNT] = '{15, 0,   0,   127, 0,   50,  50,  20,  0};
      static int phase_sat_hi[PHASE_COUNT] = '{40, 100, 0,   127, 127, 20,  100, 80,  0};
      logic [CHAN_W-1:0] r, g, b;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed pixels under the reset bounds (hue 13..42, saturation 15..40).
      send_pixel(8'd0,   8'd0,   8'd0);     // black: no spread, never skin
      send_pixel(8'd255, 8'd255, 8'd255);   // white
      send_pixel(8'd128, 8'd128, 8'd128);   // mid gray
      send_pixel(8'd1,   8'd0,   8'd0);     // smallest spread, full saturation
      send_pixel(8'd255, 8'd0,   8'd0);     // pure red, hue zero
      send_pixel(8'd0,   8'd255, 8'd0);     // pure green
      send_pixel(8'd0,   8'd0,   8'd255);   // pure blue
      send_pixel(8'd255, 8'd255, 8'd0);     // red ties green: green formula applies
      send_pixel(8'd0,   8'd255, 8'd255);   // green ties blue: blue formula applies
      send_pixel(8'd255, 8'd0,   8'd255);   // red ties blue: blue formula applies
      send_pixel(8'd255, 8'd0,   8'd10);    // red maximum with negative hue, wraps
      send_pixel(8'd200, 8'd150, 8'd130);   // typical skin tone
      send_pixel(8'd220, 8'd180, 8'd160);   // another skin tone
      send_pixel(8'd200, 8'd185, 8'd150);   // hue exactly on the upper bound
      send_pixel(8'd200, 8'd153, 8'd140);   // hue exactly on the lower bound
      send_pixel(8'd200, 8'd177, 8'd170);   // saturation exactly on the lower bound
      send_pixel(8'd199, 8'd176, 8'd169);   // just inside both bands
      send_pixel(8'd200, 8'd147, 8'd120);   // saturation exactly on the upper bound
      send_pixel(8'd255, 8'd254, 8'd0);     // near-yellow edge of red maximum
      send_pixel(8'd254, 8'd0,   8'd255);   // blue barely over red
      drain_pipe();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase == PHASE_COUNT - 1) begin
            phase_hue_lo[phase] = $urandom_range((1 << HUE_W) - 1);
            phase_hue_hi[phase] = $urandom_range((1 << HUE_W) - 1);
            phase_sat_lo[phase] = $urandom_range((1 << SAT_W) - 1);
            phase_sat_hi[phase] = $urandom_range((1 << SAT_W) - 1);
         end
         set_bounds(phase_hue_lo[phase], phase_hue_hi[phase],
                    phase_sat_lo[phase], phase_sat_hi[phase]);
         // Two phases run with both sides always ready, giving a long stretch at
         // full rate with no gaps.
         stall_pct = (phase == 3 || phase == 4) ? 0 : STALL_PCT;
         for (int n = 0; n < PHASE_PIXELS; n++) begin
            pick_pixel(r, g, b);
            send_pixel(r, g, b);
         end
         drain_pipe();
      end

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/hsvskin_pkg.sv
hdl/hsvskin_prep.sv
hdl/hsv_skin_pixel_classifier.sv
tb/hsv_skin_checker.sv
tb/testbench.sv
